>>> design/gaussian_partition_wall_gradient_top_defines.svh
// assertion macros shared by the checker
`ifndef GAUSSIAN_PARTITION_WALL_GRADIENT_TOP_DEFINES_SVH
`define GAUSSIAN_PARTITION_WALL_GRADIENT_TOP_DEFINES_SVH

// same-cycle implication
`define GPWG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpwg assertion failed");

// next-cycle implication
`define GPWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpwg assertion failed");

`endif

>>> design/gpwg_pkg.sv
`timescale 1ns / 1ps
package gpwg_pkg;

   localparam logic [2:0] CSR_DIMENSION     = 3'd0;
   localparam logic [2:0] CSR_BETA          = 3'd1;
   localparam logic [2:0] CSR_RANGE_SQUARED = 3'd2;
   localparam logic [2:0] CSR_WALL_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_INSIDE_COUNT  = 3'd4;
   localparam logic [2:0] CSR_MARKER_COUNT  = 3'd5;

   localparam int SQ_W  = 49;
   localparam int D2_W  = 51;
   localparam int DW    = 65;
   localparam int WAIT_W = 7;
   localparam logic [WAIT_W-1:0] DIV_ITER     = 7'd65;
   localparam logic [WAIT_W-1:0] DRAIN_CYCLES = 7'd10;
   localparam int LANE_PIPE = 5;
   localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MUL1,
      ST_DIV1,
      ST_SUB,
      ST_MUL2,
      ST_DIV2,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic outer;
   } walk_ctl_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic outer;
   } acc_ctl_type;

   typedef struct packed {
      logic mul1;
      logic div;
      logic sub;
      logic mul2;
   } post_cmd_type;

endpackage

>>> design/gaussian_partition_wall_gradient_top.sv
`timescale 1ns / 1ps
// load beat: written straight into the marker store
// query beat: the store gives one marker a cycle
// then per-axis lanes run two bit-serial divisions
// one query in flight; a finished response may wait while the next beat is taken
// reset: control state cleared, registers back to defaults, marker store left as is
module gaussian_partition_wall_gradient_top import gpwg_pkg::*; #(
   parameter int MARKER_DEPTH    = 1024,
   parameter int MAX_DIM         = 3,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // marker_index, coord_x, coord_y, coord_z
   input  logic         req_tuser,  // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // grad_x, grad_y, grad_z
   output logic         rsp_tuser,  // no_neighbour
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int AW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
   localparam int CW = $clog2(MARKER_DEPTH + 1);
   localparam int ZW = $clog2(MARKER_DEPTH + 1) + 16;

   logic [1:0]  dim_ff;
   logic [31:0] beta_ff, range_ff, height_ff;
   logic [10:0] inside_ff, count_ff;

   state_type         state_ff, state_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [CW-1:0]     idx_ff, lim_ff;
   logic              rd_en, clear, rsp_load, req_acc, more;
   post_cmd_type      cmd;
   walk_ctl_type      ctl_s1_ff;

   logic [95:0] mem [MARKER_DEPTH];
   logic [95:0] rdata_ff;
   logic [31:0] q_ff [3];
   logic [9:0]  slot;

   logic [1:0]      nd;
   logic [SQ_W-1:0] lane_sq [MAX_DIM];
   logic [31:0]     lane_grad [MAX_DIM];
   logic [31:0]     out_grad [3];
   acc_ctl_type     ctl_s7;
   logic [31:0]     bw;
   logic [ZW-1:0]   z, wout;
   logic            found, ok;

   logic        rsp_valid_ff, rsp_nn_ff;
   logic [95:0] rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= 2'd3;
         beta_ff   <= 32'd65536;
         range_ff  <= 32'd262144;
         height_ff <= 32'd65536;
         inside_ff <= '0;
         count_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIMENSION:     dim_ff    <= csr_data[1:0];
            CSR_BETA:          beta_ff   <= csr_data;
            CSR_RANGE_SQUARED: range_ff  <= csr_data;
            CSR_WALL_HEIGHT:   height_ff <= csr_data;
            CSR_INSIDE_COUNT:  inside_ff <= csr_data[10:0];
            CSR_MARKER_COUNT:  count_ff  <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (dim_ff == 2'd0) begin
         nd = 2'd1;
      end else if (32'(dim_ff) > MAX_DIM) begin
         nd = 2'(MAX_DIM);
      end else begin
         nd = dim_ff;
      end
   end

   assign req_acc = req_tvalid && req_tready;
   assign slot    = req_tdata[9:0];
   assign more    = idx_ff < lim_ff;

   always_ff @(posedge clock) begin
      if (req_acc && !req_tuser && (32'(slot) < MARKER_DEPTH)) begin
         mem[AW'(slot)] <= req_tdata[105:10];
      end
      if (rd_en) begin
         rdata_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         q_ff[0] <= req_tdata[41:10];
         q_ff[1] <= req_tdata[73:42];
         q_ff[2] <= req_tdata[105:74];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid && req_tuser) state_in = ST_WALK;
         ST_WALK:  if (!more) state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (wait_ff == DRAIN_CYCLES) begin
               state_in = (found && z != '0) ? ST_MUL1 : ST_FIN;
            end
         end
         ST_MUL1:  state_in = ST_DIV1;
         ST_DIV1:  if (wait_ff == DIV_ITER) state_in = ST_SUB;
         ST_SUB:   state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DIV2;
         ST_DIV2:  if (wait_ff == DIV_ITER) state_in = ST_FIN;
         ST_FIN:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      clear      = 1'b0;
      rsp_load   = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            clear      = req_tvalid && req_tuser;
         end
         ST_WALK:  rd_en    = more;
         ST_MUL1:  cmd.mul1 = 1'b1;
         ST_DIV1:  cmd.div  = (wait_ff == '0);
         ST_SUB:   cmd.sub  = 1'b1;
         ST_MUL2:  cmd.mul2 = 1'b1;
         ST_DIV2:  cmd.div  = (wait_ff == '0);
         ST_FIN:   rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign wait_in = (state_in != state_ff) ? '0 : WAIT_W'(wait_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wait_ff   <= '0;
         idx_ff    <= '0;
         lim_ff    <= '0;
         ctl_s1_ff <= '0;
      end else begin
         state_ff  <= state_in;
         wait_ff   <= wait_in;
         ctl_s1_ff <= '{valid: rd_en, outer: (32'(idx_ff) >= 32'(inside_ff))};
         if (clear) begin
            idx_ff <= '0;
            lim_ff <= (32'(count_ff) > MARKER_DEPTH) ? CW'(MARKER_DEPTH) : CW'(count_ff);
         end else if (rd_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   for (genvar a = 0; a < MAX_DIM; a++) begin : g_lane
      gpwg_lane #(.ZW(ZW)) u_lane (
         .clock       (clock),
         .reset       (reset),
         .clear       (clear),
         .en          (32'(nd) > a),
         .q           (q_ff[a]),
         .mk          (rdata_ff[32*a +: 32]),
         .sq          (lane_sq[a]),
         .ctl_s7      (ctl_s7),
         .bw          (bw),
         .cmd         (cmd),
         .z           (z),
         .wout        (wout),
         .wall_height (height_ff),
         .grad        (lane_grad[a])
      );
   end

   gpwg_merge #(
      .MAX_DIM         (MAX_DIM),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
      .ZW              (ZW)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear),
      .ctl_s1   (ctl_s1_ff),
      .sq       (lane_sq),
      .beta     (beta_ff),
      .range_sq (range_ff),
      .ctl_s7   (ctl_s7),
      .bw       (bw),
      .z        (z),
      .wout     (wout),
      .found    (found)
   );

   assign ok = found && (z != '0);

   for (genvar a = 0; a < 3; a++) begin : g_out
      if (a < MAX_DIM) begin : g_used
         assign out_grad[a] = ok ? lane_grad[a] : '0;
      end else begin : g_unused
         assign out_grad[a] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {out_grad[2], out_grad[1], out_grad[0]};
         rsp_nn_ff   <= !found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_nn_ff;

endmodule

>>> design/gpwg_div.sv
`timescale 1ns / 1ps
module gpwg_div import gpwg_pkg::*; #(
   parameter int ZW = 27
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [ZW-1:0] den,
   output logic [DW-1:0] quo
);

   logic [ZW-1:0]     rem_ff;
   logic [DW-1:0]     quo_ff;
   logic [WAIT_W-1:0] cnt_ff;
   logic [ZW:0]       trial;
   logic              take;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign take  = trial >= {1'b0, den};
   assign quo   = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_ITER;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
      end else if (cnt_ff != '0) begin
         rem_ff <= take ? ZW'(trial - {1'b0, den}) : trial[ZW-1:0];
         quo_ff <= {quo_ff[DW-2:0], take};
      end
   end

endmodule

>>> design/gpwg_lane.sv
`timescale 1ns / 1ps
module gpwg_lane import gpwg_pkg::*; #(
   parameter int ZW = 27
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  logic            en,
   input  logic [31:0]     q,
   input  logic [31:0]     mk,
   output logic [SQ_W-1:0] sq,
   input  acc_ctl_type     ctl_s7,
   input  logic [31:0]     bw,
   input  post_cmd_type    cmd,
   input  logic [ZW-1:0]   z,
   input  logic [ZW-1:0]   wout,
   input  logic [31:0]     wall_height,
   output logic [31:0]     grad
);

   function automatic logic [31:0] sat32(input logic signed [50:0] v);
      if (v > 51'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -51'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic [32:0]        mag_ff;
   logic               neg_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [65:0]        sqp;
   logic [32:0]        mag_pipe_ff [LANE_PIPE];
   logic               neg_pipe_ff [LANE_PIPE];
   logic [64:0]        prod;
   logic [47:0]        term_s8_ff;
   logic               neg_s8_ff;
   acc_ctl_type        ctl_s8_ff;
   logic signed [50:0] term_sv;
   logic [31:0]        dz_ff, go_ff;
   logic [31:0]        dz_in, go_in;
   logic [31:0]        abs_dz;
   logic [DW-1:0]      num_ff;
   logic               sgn_ff;
   logic [DW-1:0]      quo;
   logic signed [33:0] qs, t;
   logic               tneg_ff;
   logic [32:0]        tmag_ff;
   logic [31:0]        res;

   assign diff = $signed({q[31], q}) - $signed({mk[31], mk});
   assign mag  = diff[32] ? 33'(~diff + 33'd1) : diff;
   assign sqp  = 66'(mag_ff) * 66'(mag_ff);
   assign sq   = sq_ff;

   always_ff @(posedge clock) begin
      mag_ff <= en ? mag : '0;
      neg_ff <= diff[32];
      sq_ff  <= sqp[64:16];
      mag_pipe_ff[0] <= mag_ff;
      neg_pipe_ff[0] <= neg_ff;
      for (int k = 1; k < LANE_PIPE; k++) begin
         mag_pipe_ff[k] <= mag_pipe_ff[k-1];
         neg_pipe_ff[k] <= neg_pipe_ff[k-1];
      end
   end

   assign prod = 65'(bw) * 65'(mag_pipe_ff[LANE_PIPE-1]);

   always_ff @(posedge clock) begin
      term_s8_ff <= prod[63:16];
      neg_s8_ff  <= neg_pipe_ff[LANE_PIPE-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s8_ff <= '0;
      end else begin
         ctl_s8_ff <= ctl_s7;
      end
   end

   // sign of the term is opposite to the difference
   assign term_sv = neg_s8_ff ? $signed({2'b00, term_s8_ff, 1'b0})
                              : -$signed({2'b00, term_s8_ff, 1'b0});

   always_comb begin
      dz_in = dz_ff;
      go_in = go_ff;
      if (clear) begin
         dz_in = '0;
         go_in = '0;
      end else if (ctl_s8_ff.valid && ctl_s8_ff.hit) begin
         dz_in = sat32($signed({{19{dz_ff[31]}}, dz_ff}) + term_sv);
         if (ctl_s8_ff.outer) begin
            go_in = sat32($signed({{19{go_ff[31]}}, go_ff}) + term_sv);
         end
      end
   end

   always_ff @(posedge clock) begin
      dz_ff <= dz_in;
      go_ff <= go_in;
   end

   assign abs_dz = dz_ff[31] ? 32'(~dz_ff + 32'd1) : dz_ff;
   assign qs = sgn_ff ? -$signed({2'b00, quo[31:0]}) : $signed({2'b00, quo[31:0]});
   assign t  = qs - $signed({{2{go_ff[31]}}, go_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         num_ff <= DW'(abs_dz) * DW'(wout);
         sgn_ff <= dz_ff[31];
      end else if (cmd.mul2) begin
         num_ff <= DW'(wall_height) * DW'(tmag_ff);
      end
      if (cmd.sub) begin
         tneg_ff <= t[33];
         tmag_ff <= t[33] ? 33'(-t) : t[32:0];
      end
   end

   gpwg_div #(.ZW(ZW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div),
      .num   (num_ff),
      .den   (z),
      .quo   (quo)
   );

   always_comb begin
      if (tneg_ff) begin
         res = (quo > 65'h0_8000_0000) ? 32'h8000_0000 : 32'(~quo[31:0] + 32'd1);
      end else begin
         res = (quo > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      end
   end

   assign grad = en ? res : '0;

endmodule

>>> design/gpwg_merge.sv
`timescale 1ns / 1ps
module gpwg_merge import gpwg_pkg::*; #(
   parameter int MAX_DIM         = 3,
   parameter int EXP_TABLE_DEPTH = 256,
   parameter int ZW              = 27
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  walk_ctl_type    ctl_s1,
   input  logic [SQ_W-1:0] sq [MAX_DIM],
   input  logic [31:0]     beta,
   input  logic [31:0]     range_sq,
   output acc_ctl_type     ctl_s7,
   output logic [31:0]     bw,
   output logic [ZW-1:0]   z,
   output logic [ZW-1:0]   wout,
   output logic            found
);

   localparam int TW = $clog2(EXP_TABLE_DEPTH);

   typedef logic [16:0] tab_type [EXP_TABLE_DEPTH];

   function automatic tab_type build_tab();
      tab_type      tb;
      logic [127:0] v;
      v = 128'h1_0000_0000;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         tb[k] = 17'((v + 128'd32768) >> 16);
         v = ((v * 128'(EXP_STEP_Q32)) + 128'h8000_0000) >> 32;
      end
      return tb;
   endfunction

   localparam tab_type EXP_TAB = build_tab();

   walk_ctl_type    ctl_s2_ff, ctl_s3_ff;
   acc_ctl_type     ctl_s4_ff, ctl_s5_ff, ctl_s6_ff, ctl_s7_ff;
   logic [D2_W-1:0] d2_sum;
   logic [31:0]     d2lo_s4_ff;
   logic [63:0]     arg_s5_ff;
   logic [35:0]     idx;
   logic [16:0]     w_s6_ff, w_s7_ff, w_lut;
   logic [48:0]     bwp;
   logic [31:0]     bw_s7_ff;
   logic [ZW-1:0]   z_ff, wout_ff;
   logic            found_ff;

   always_comb begin
      d2_sum = '0;
      for (int a = 0; a < MAX_DIM; a++) begin
         d2_sum = d2_sum + D2_W'(sq[a]);
      end
   end

   assign idx   = arg_s5_ff[63:28];
   assign w_lut = (idx < 36'(EXP_TABLE_DEPTH)) ? EXP_TAB[idx[TW-1:0]] : '0;
   assign bwp   = 49'(beta) * 49'(w_s6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
         ctl_s4_ff <= '0;
         ctl_s5_ff <= '0;
         ctl_s6_ff <= '0;
         ctl_s7_ff <= '0;
      end else begin
         ctl_s2_ff <= ctl_s1;
         ctl_s3_ff <= ctl_s2_ff;
         ctl_s4_ff <= '{valid: ctl_s3_ff.valid,
                        hit:   ctl_s3_ff.valid && (d2_sum <= D2_W'(range_sq)),
                        outer: ctl_s3_ff.outer};
         ctl_s5_ff <= ctl_s4_ff;
         ctl_s6_ff <= ctl_s5_ff;
         ctl_s7_ff <= ctl_s6_ff;
      end
   end

   always_ff @(posedge clock) begin
      d2lo_s4_ff <= d2_sum[31:0];
      arg_s5_ff  <= 64'(beta) * 64'(d2lo_s4_ff);
      w_s6_ff    <= w_lut;
      w_s7_ff    <= w_s6_ff;
      bw_s7_ff   <= bwp[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         z_ff     <= '0;
         wout_ff  <= '0;
         found_ff <= 1'b0;
      end else if (ctl_s7_ff.valid && ctl_s7_ff.hit) begin
         z_ff     <= z_ff + ZW'(w_s7_ff);
         found_ff <= 1'b1;
         if (ctl_s7_ff.outer) begin
            wout_ff <= wout_ff + ZW'(w_s7_ff);
         end
      end
   end

   assign ctl_s7 = ctl_s7_ff;
   assign bw     = bw_s7_ff;
   assign z      = z_ff;
   assign wout   = wout_ff;
   assign found  = found_ff;

endmodule

>>> design/gpwg_checker.sv
`timescale 1ns / 1ps
`include "gaussian_partition_wall_gradient_top_defines.svh"
module gpwg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   `GPWG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `GPWG_ASSERT_SAME(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 96'd0)
   `GPWG_ASSERT_NEXT(a_query_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)
   `GPWG_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind gaussian_partition_wall_gradient_top gpwg_checker u_checker (.*);
